>>> rtl/core/tts_pkg.sv
// shared types and constants for the tick task scheduler
`default_nettype none
package tts_pkg;
  localparam int MAX_TASKS = 64;
  localparam int TIME_BITS = 20;
  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_DONE  = 2'd2;
  localparam logic       KIND_DISPATCH = 1'b0;
  localparam logic       KIND_PASS_END = 1'b1;
  localparam logic [1:0] CFG_LOOP_PERIOD = 2'd0;
  localparam logic [1:0] CFG_TASK_COUNT  = 2'd1;
  localparam logic [1:0] CFG_SLOWDOWN    = 2'd2;
  localparam logic [12:0] BUDGET_CAP  = 13'd5000;
  localparam logic [12:0] BUDGET_UP   = 13'd100;
  localparam logic [12:0] BUDGET_DOWN = 13'd50;
  localparam logic [5:0]  CLEAN_LIMIT = 6'd50;
  localparam logic [4:0]  SPARE_WRAP  = 5'd31;
  localparam logic [20:0] SPARE_MAX   = 21'h1FFFFF;

  typedef struct packed {
    logic [1:0]  func;
    logic [5:0]  task_index;
    logic [15:0] period_ticks;
    logic [15:0] budget_us;
    logic        fast_task;
    logic [19:0] time_us;
  } tts_in_t;

  typedef struct packed {
    logic        kind;
    logic [5:0]  run_index;
    logic [15:0] allowed_us;
    logic        slipped;
    logic        prev_overrun;
    logic [20:0] spare_us;
    logic [4:0]  spare_count;
    logic [12:0] extra_budget_us;
  } tts_out_t;

  typedef struct packed {
    logic [15:0] interval;
    logic [15:0] budget;
    logic        fast;
  } tts_entry_t;
endpackage
`default_nettype wire

>>> rtl/core/tick_task_scheduler.sv
// top level of the tick task scheduler
`default_nettype none
// One item at a time. A table write goes into the table memory as the item
// is taken. A tick or done report scans the task table through the table
// memory, a read state and an evaluate state per slot. A dispatch is
// registered in the evaluate state of its slot, a pass end in the output
// state after the end state, and a done report that uses up the time goes
// straight to the end state. After reset a clearing pass writes zero into
// every last run tick entry, with no item taken meanwhile.
// The result sits in an output register; a new item is taken once it is gone.
module tick_task_scheduler import tts_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire tts_in_t in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output tts_out_t   out_data,
  input  wire logic  cfg_valid,
  output logic       cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [14:0] cfg_data
);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CW = $clog2(MAX_TASKS + 1) + 1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001, S_IDLE = 6'b000010, S_READ = 6'b000100,
    S_EVAL  = 6'b001000, S_END  = 6'b010000, S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [14:0] loop_r;
  logic [6:0]  tcount_r;
  logic [4:0]  slow_r;
  logic [15:0] tick_r;
  logic [CW-1:0] pos_r;
  logic [TIME_BITS-1:0] left_r;
  logic [15:0] cur_r;
  logic pass_r, na_r, ovr_r;
  logic [5:0]  clean_r;
  logic [12:0] extra_r;
  logic [20:0] spare_r;
  logic [4:0]  spcnt_r;
  tts_out_t    out_r;
  logic        ov_r;

  tts_entry_t  t_rd;
  logic [15:0] l_rd;
  logic lw_en;
  logic [AW-1:0] lw_addr;
  logic [15:0] lw_data;
  logic [CW-1:0] n_lim;

  assign n_lim = (tcount_r > 7'(MAX_TASKS)) ? CW'(MAX_TASKS) : CW'(tcount_r);

  logic take;
  assign in_stall = !(state_r == S_IDLE) || ov_r;
  assign take = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = ov_r;
  assign out_data = out_r;

  tts_table #(.AW(AW)) u_table (
    .clk(clk),
    .tw_en(take && in_data.func == FUNC_WRITE && 32'(in_data.task_index) < MAX_TASKS),
    .tw_addr(AW'(in_data.task_index)),
    .tw_data({in_data.period_ticks, in_data.budget_us, in_data.fast_task}),
    .lw_en(lw_en), .lw_addr(lw_addr), .lw_data(lw_data),
    .rd_addr(pos_r[AW-1:0]), .t_rd(t_rd), .l_rd(l_rd)
  );

  // evaluation of the slot read
  logic [15:0] dt, iv;
  logic [16:0] iv2;
  logic [20:0] ivs;
  logic due, fits, slip_e;
  always_comb begin
    dt = tick_r - l_rd;
    iv = (t_rd.interval == 16'd0) ? 16'd1 : t_rd.interval;
    iv2 = {iv, 1'b0};
    ivs = iv * slow_r;
    due = t_rd.fast || dt >= iv;
    fits = t_rd.fast || TIME_BITS'(t_rd.budget) <= left_r;
    slip_e = !t_rd.fast && 17'(dt) >= iv2;
  end

  // pass end arithmetic
  logic [21:0] ssum;
  logic [20:0] sacc;
  logic [4:0]  spn;
  logic [13:0] ebump;
  always_comb begin
    ssum = 22'(spare_r) + 22'(left_r);
    sacc = ssum[21] ? SPARE_MAX : ssum[20:0];
    spn = spcnt_r + 5'd1;
    ebump = 14'(extra_r) + 14'(BUDGET_UP);
  end

  logic [TIME_BITS:0] avail;
  assign avail = (TIME_BITS+1)'(in_data.time_us) + (TIME_BITS+1)'(extra_r);

  always_comb begin
    state_nxt = state_r;
    lw_en = 1'b0;
    lw_addr = pos_r[AW-1:0];
    lw_data = tick_r;
    case (state_r)
      S_CLEAR: begin
        lw_en = 1'b1;
        lw_data = 16'd0;
        if (pos_r == CW'(MAX_TASKS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: if (take) begin
        if (in_data.func == FUNC_TICK) state_nxt = S_READ;
        else if (in_data.func == FUNC_DONE && pass_r) begin
          lw_en = pos_r < CW'(MAX_TASKS);
          if (32'(in_data.time_us) >= 32'(left_r)) state_nxt = S_END;
          else state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = (pos_r < n_lim) ? S_EVAL : S_END;
      S_EVAL: state_nxt = (due && fits) ? S_OUT : S_READ;
      S_END: state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      loop_r <= 15'd2500; tcount_r <= 7'd0; slow_r <= 5'd4;
      tick_r <= '0; pos_r <= '0; left_r <= '0; cur_r <= '0;
      pass_r <= 1'b0; na_r <= 1'b0; ovr_r <= 1'b0;
      clean_r <= '0; extra_r <= '0; spare_r <= '0; spcnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          CFG_LOOP_PERIOD: loop_r <= cfg_data;
          CFG_TASK_COUNT:  tcount_r <= cfg_data[6:0];
          CFG_SLOWDOWN:    slow_r <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (ov_r && !out_stall) ov_r <= 1'b0;
      case (state_r)
        S_CLEAR: pos_r <= (pos_r == CW'(MAX_TASKS - 1)) ? '0 : pos_r + 1'b1;
        S_IDLE: if (take) begin
          if (in_data.func == FUNC_TICK) begin
            tick_r <= tick_r + 16'd1;
            left_r <= avail[TIME_BITS] ? TIME_MAX : avail[TIME_BITS-1:0];
            pos_r <= '0; pass_r <= 1'b1; ovr_r <= 1'b0;
          end else if (in_data.func == FUNC_DONE && pass_r) begin
            ovr_r <= 32'(in_data.time_us) > 32'(cur_r);
            if (32'(in_data.time_us) >= 32'(left_r)) left_r <= '0;
            else begin
              left_r <= left_r - TIME_BITS'(in_data.time_us);
              pos_r <= pos_r + 1'b1;
            end
          end
        end
        S_EVAL: begin
          if (due && !t_rd.fast && 32'(dt) >= 32'(ivs)) na_r <= 1'b1;
          if (due && fits) begin
            cur_r <= t_rd.fast ? 16'(loop_r) : t_rd.budget;
            out_r <= '{KIND_DISPATCH, pos_r[5:0],
                       t_rd.fast ? 16'(loop_r) : t_rd.budget,
                       slip_e, ovr_r, spare_r, spcnt_r, extra_r};
            ov_r <= 1'b1;
          end else pos_r <= pos_r + 1'b1;
        end
        S_END: begin
          if (spn == SPARE_WRAP + 5'd1) begin
            spcnt_r <= 5'd16; spare_r <= sacc >> 1;
          end else begin
            spcnt_r <= spn; spare_r <= sacc;
          end
          pass_r <= 1'b0; pos_r <= '0;
          if (na_r) begin
            extra_r <= (ebump > 14'(BUDGET_CAP)) ? BUDGET_CAP : ebump[12:0];
            na_r <= 1'b0; clean_r <= '0;
          end else if (extra_r != 13'd0) begin
            if (clean_r + 6'd1 > CLEAN_LIMIT) begin
              clean_r <= '0;
              extra_r <= (extra_r >= BUDGET_DOWN) ? extra_r - BUDGET_DOWN : 13'd0;
            end else clean_r <= clean_r + 6'd1;
          end
        end
        S_OUT: if (!(state_r == S_OUT && ov_r)) begin
          out_r <= '{KIND_PASS_END, 6'd0, 16'd0, 1'b0, ovr_r,
                     spare_r, spcnt_r, extra_r};
          ov_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall) else $error("item taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(out_r))) else $error("result lost");
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (pos_r < n_lim)) else $error("scan past table");
endmodule
`default_nettype wire

>>> rtl/core/tts_table.sv
// task table and last run tick memories, one registered read port each
`default_nettype none
module tts_table import tts_pkg::*; #(
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          tw_en,
  input  wire logic [AW-1:0] tw_addr,
  input  wire tts_entry_t    tw_data,
  input  wire logic          lw_en,
  input  wire logic [AW-1:0] lw_addr,
  input  wire logic [15:0]   lw_data,
  input  wire logic [AW-1:0] rd_addr,
  output tts_entry_t         t_rd,
  output logic [15:0]        l_rd
);
  tts_entry_t  tmem [2**AW];
  logic [15:0] lmem [2**AW];
  always_ff @(posedge clk) begin
    if (tw_en) tmem[tw_addr] <= tw_data;
    t_rd <= tmem[rd_addr];
  end
  always_ff @(posedge clk) begin
    if (lw_en) lmem[lw_addr] <= lw_data;
    l_rd <= lmem[rd_addr];
  end
endmodule
`default_nettype wire
